FILE: rtl/tia_pkg.sv
// Package for the typed identifier allocator: field widths, status and
// command codes, parameter defaults and the front-to-back command struct.
// No dependencies.
package tia_pkg;

	// parameter defaults
	localparam int ID_BITS_DEF    = 16;
	localparam int FREE_DEPTH_DEF = 256;
	localparam int NUM_KINDS_DEF  = 4;

	// fixed field widths
	localparam int FUNC_W   = 1;
	localparam int KIND_W   = 2;
	localparam int IDENT_W  = 16;
	localparam int STATUS_W = 3;

	// func field codes
	localparam logic [FUNC_W-1:0] FN_RELEASE  = 1'b0;
	localparam logic [FUNC_W-1:0] FN_ALLOCATE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

	// classified command codes
	localparam logic [1:0] OP_PUSH   = 2'd0; // release with a valid kind and nonzero id
	localparam logic [1:0] OP_POP    = 2'd1; // allocate with a valid kind
	localparam logic [1:0] OP_DROP   = 2'd2; // release that is rejected up front
	localparam logic [1:0] OP_NOKIND = 2'd3; // allocate on a kind without a stack

	typedef struct packed {
		logic [1:0]         op;
		logic [KIND_W-1:0]  kind;
		logic [IDENT_W-1:0] ident;
	} cmd_t;

endpackage

FILE: rtl/tia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tia_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tia_front.sv
// Front end: accepts input beats, classifies them into commands and queues
// them in a two-entry FIFO for the back end. Uses tia_pkg.
module tia_front
	import tia_pkg::*;
#(
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int NUM_KINDS = NUM_KINDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [KIND_W-1:0]  kind,
	input  logic [IDENT_W-1:0] ident,
	output logic               q_valid,
	input  logic               q_ready,
	output cmd_t               q_cmd
);

	localparam logic [IDENT_W-1:0] IDENT_MASK = (ID_BITS >= IDENT_W) ? '1 :
		IDENT_W'((64'd1 << ID_BITS) - 64'd1);

	cmd_t             cmd;
	logic             kind_ok;
	logic [IDENT_W-1:0] ident_m;
	cmd_t             fifo_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign ident_m = ident & IDENT_MASK;
	assign kind_ok = 32'(kind) < NUM_KINDS;

	always_comb begin
		cmd.kind  = kind;
		cmd.ident = ident_m;
		priority if (!kind_ok) begin
			cmd.op = (func == FN_ALLOCATE) ? OP_NOKIND : OP_DROP;
		end else if (func == FN_ALLOCATE) begin
			cmd.op = OP_POP;
		end else if (ident_m == '0) begin
			// a zero id is never pushed onto a stack: drop it
			cmd.op = OP_DROP;
		end else begin
			cmd.op = OP_PUSH;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/tia_back.sv
// Back end: keeps per-kind stack depths and fresh counters, drives the free
// store RAM and holds the result in an output register. Uses tia_pkg, tia_ram.
module tia_back
	import tia_pkg::*;
#(
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int FREE_DEPTH = FREE_DEPTH_DEF,
	parameter int NUM_KINDS  = NUM_KINDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  cmd_t                q_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [IDENT_W-1:0]  given_id,
	output logic [STATUS_W-1:0] status
);

	localparam int MEM_DEPTH = NUM_KINDS * FREE_DEPTH;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int DEPTH_W   = $clog2(FREE_DEPTH + 1);
	localparam int KIX_W     = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
	localparam int FRESH_W   = ID_BITS + 1;

	logic [DEPTH_W-1:0]  depth_q [NUM_KINDS];
	logic [FRESH_W-1:0]  fresh_q [NUM_KINDS];
	logic [KIX_W-1:0]    kix;
	logic [DEPTH_W-1:0]  d_cur;
	logic [FRESH_W-1:0]  f_cur;
	logic [DEPTH_W-1:0]  d_dec;
	logic [AW-1:0]       base;
	logic                issue;
	logic                do_push;
	logic                do_pop;
	logic                do_fresh;
	logic [STATUS_W-1:0] st_nxt;
	logic [ID_BITS-1:0]  rdata;

	logic                valid_s1;
	logic                reuse_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [IDENT_W-1:0]  given_s1;

	assign kix   = KIX_W'(q_cmd.kind);
	assign d_cur = depth_q[kix];
	assign f_cur = fresh_q[kix];
	assign d_dec = d_cur - DEPTH_W'(1);
	assign base  = AW'(kix) * AW'(FREE_DEPTH);

	// advance whenever the output register is empty or being emptied
	assign q_ready = !valid_s1 || out_ready;
	assign issue   = q_valid && q_ready;

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_fresh = 1'b0;
		unique case (q_cmd.op)
			OP_PUSH: begin
				if (d_cur == DEPTH_W'(FREE_DEPTH)) begin
					st_nxt = ST_DROPPED;
				end else begin
					do_push = 1'b1;
					st_nxt  = ST_KEPT;
				end
			end
			OP_POP: begin
				priority if (d_cur != '0) begin
					do_pop = 1'b1;
					st_nxt = ST_REUSED;
				end else if (!f_cur[ID_BITS]) begin
					do_fresh = 1'b1;
					st_nxt   = ST_FRESH;
				end else begin
					st_nxt = ST_EXHAUSTED;
				end
			end
			OP_DROP:   st_nxt = ST_DROPPED;
			OP_NOKIND: st_nxt = ST_EXHAUSTED;
			default:   st_nxt = ST_DROPPED;
		endcase
	end

	tia_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (issue && do_push),
		.waddr (base + AW'(d_cur)),
		.wdata (ID_BITS'(q_cmd.ident)),
		.re    (issue && do_pop),
		.raddr (base + AW'(d_dec)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int k = 0; k < NUM_KINDS; k++) begin
				depth_q[k] <= '0;
				fresh_q[k] <= '0;
			end
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
			if (issue && do_push) begin
				depth_q[kix] <= d_cur + DEPTH_W'(1);
			end
			if (issue && do_pop) begin
				depth_q[kix] <= d_dec;
			end
			if (issue && do_fresh) begin
				fresh_q[kix] <= f_cur + FRESH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			reuse_s1  <= do_pop;
			status_s1 <= st_nxt;
			given_s1  <= do_fresh ? IDENT_W'(f_cur) : '0;
		end
	end

	assign out_valid = valid_s1;
	assign status    = status_s1;
	assign given_id  = reuse_s1 ? IDENT_W'(rdata) : given_s1;

endmodule

FILE: rtl/typed_id_allocator.sv
// Top level of the typed identifier allocator: front end, command queue and
// back end. Uses tia_pkg, tia_front, tia_back.
//
// Hands out identifiers for NUM_KINDS resource kinds, each with a LIFO stack
// of released ids (FREE_DEPTH entries, kept in one RAM) and a fresh counter
// from 0. An allocate returns the most recently released id of its kind, else
// the counter value; a release pushes its id unless it is zero, the stack is
// full or the kind has no stack. Every beat gives one result. The block
// sustains one beat per cycle while the output is not stalled: each item makes
// at most one free store access in the back end, whose depth registers update in
// the same cycle, so back-to-back allocations and releases on one kind follow
// each other without a bubble. From input acceptance to output valid a command
// passes the command queue and then the back-end output register; a two-entry
// queue lets the input keep accepting while a result waits. No clearing pass is
// needed after reset.
module typed_id_allocator
	import tia_pkg::*;
#(
	parameter int ID_BITS    = ID_BITS_DEF,
	parameter int FREE_DEPTH = FREE_DEPTH_DEF,
	parameter int NUM_KINDS  = NUM_KINDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [KIND_W-1:0]   kind,
	input  logic [IDENT_W-1:0]  ident,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [IDENT_W-1:0]  given_id,
	output logic [STATUS_W-1:0] status
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	tia_front #(
		.ID_BITS   (ID_BITS),
		.NUM_KINDS (NUM_KINDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.kind     (kind),
		.ident    (ident),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	tia_back #(
		.ID_BITS    (ID_BITS),
		.FREE_DEPTH (FREE_DEPTH),
		.NUM_KINDS  (NUM_KINDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.given_id  (given_id),
		.status    (status)
	);

endmodule

FILE: rtl/tia_checker.sv
// Port-level checker for the typed identifier allocator, bound to the top.
// Uses tia_pkg.
module tia_checker
	import tia_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [FUNC_W-1:0]   func,
	input logic [KIND_W-1:0]   kind,
	input logic [IDENT_W-1:0]  ident,
	input logic                out_valid,
	input logic                out_ready,
	input logic [IDENT_W-1:0]  given_id,
	input logic [STATUS_W-1:0] status
);

	// a stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(func) && $stable(kind)
		&& $stable(ident))
		else $error("input beat changed while stalled");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(given_id) && $stable(status))
		else $error("result beat changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_EXHAUSTED)
		else $error("status code out of range");

	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_KEPT || status == ST_DROPPED || status == ST_EXHAUSTED)
		|-> given_id == '0)
		else $error("nonzero id on a result that allocates nothing");

	// with the output register empty the queue cannot be full
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result is pending");

endmodule

bind typed_id_allocator tia_checker u_tia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.kind      (kind),
	.ident     (ident),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.given_id  (given_id),
	.status    (status)
);

FILE: test/testbench.sv
// Self-checking testbench for typed_id_allocator: random bursts of release and
// allocate beats, checked against an in-bench model of the per-kind id stacks
// and fresh counters. Depends on rtl/tia_pkg.sv and rtl/typed_id_allocator.sv.
module testbench;
	import tia_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_BITS    = ID_BITS_DEF;
	localparam int FREE_DEPTH = FREE_DEPTH_DEF;
	localparam int NUM_KINDS  = NUM_KINDS_DEF;
	localparam logic [IDENT_W-1:0] ID_MASK = IDENT_W'((64'd1 << ID_BITS) - 1);
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_LEN   = 300;
	localparam int QUIET_MAX  = 3000;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [KIND_W-1:0]  kind;
		logic [IDENT_W-1:0] ident;
	} request_t;

	typedef struct packed {
		logic [IDENT_W-1:0]  given;
		logic [STATUS_W-1:0] status;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [KIND_W-1:0]   kind = '0;
	logic [IDENT_W-1:0]  ident = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [IDENT_W-1:0]  given_id;
	logic [STATUS_W-1:0] status;

	// model of the allocator state
	logic [IDENT_W-1:0] free_ids [NUM_KINDS][FREE_DEPTH];
	int unsigned        stack_fill [NUM_KINDS];
	logic [ID_BITS:0]   fresh_next [NUM_KINDS];

	request_t    requests_todo[$];
	grant_t      grants_due[$];
	int unsigned beats_in = 0;
	int unsigned requests_total = 0;
	int unsigned fails = 0;
	bit          in_took = 1'b0;

	typed_id_allocator #(
		.ID_BITS(ID_BITS),
		.FREE_DEPTH(FREE_DEPTH),
		.NUM_KINDS(NUM_KINDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.kind(kind),
		.ident(ident),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.given_id(given_id),
		.status(status)
	);

	always #2 clk = ~clk;

	function automatic grant_t predict_grant(request_t r);
		grant_t             g;
		int unsigned        k;
		logic [IDENT_W-1:0] id;
		g.given = '0;
		k = r.kind;
		id = r.ident & ID_MASK;
		if (k >= NUM_KINDS) begin
			g.status = (r.func == FN_ALLOCATE) ? ST_EXHAUSTED : ST_DROPPED;
		end else if (r.func == FN_RELEASE) begin
			// a zero id is dropped, so it never goes on a stack
			if (id == '0 || stack_fill[k] >= FREE_DEPTH) begin
				g.status = ST_DROPPED;
			end else begin
				free_ids[k][stack_fill[k]] = id;
				stack_fill[k]++;
				g.status = ST_KEPT;
			end
		end else if (stack_fill[k] > 0) begin
			stack_fill[k]--;
			g.given = free_ids[k][stack_fill[k]];
			g.status = ST_REUSED;
		end else if (fresh_next[k][ID_BITS] == 1'b0) begin
			g.given = IDENT_W'(fresh_next[k]);
			fresh_next[k]++;
			g.status = ST_FRESH;
		end else begin
			// counter ran out: hold it, no wrap
			g.status = ST_EXHAUSTED;
		end
		return g;
	endfunction

	task automatic queue_request(logic [FUNC_W-1:0] f, logic [KIND_W-1:0] k,
			logic [IDENT_W-1:0] id);
		request_t r;
		r.func = f;
		r.kind = k;
		r.ident = id;
		requests_todo.push_back(r);
		requests_total++;
	endtask

	task automatic queue_mixed(int unsigned count);
		logic [IDENT_W-1:0] id;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(0, 15))
				0: id = '0;
				1: id = '1;
				default: id = IDENT_W'($urandom_range(0, 16'hFFFF));
			endcase
			queue_request($urandom_range(0, 1) ? FN_ALLOCATE : FN_RELEASE,
				KIND_W'($urandom_range(0, 3)), id);
		end
	endtask

	// sender: bursts of beats with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	request_t    cur_req;

	always @(negedge clk) begin
		if (arst_n && (in_took || !in_valid)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (requests_todo.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				cur_req = requests_todo.pop_front();
				in_valid <= 1'b1;
				func <= cur_req.func;
				kind <= cur_req.kind;
				ident <= cur_req.ident;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: stall pattern that changes mode now and then, plus one long hold
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;
	int unsigned hold_left = 0;
	bit          held_once = 1'b0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held_once && beats_in >= HOLD_AFTER) begin
			held_once = 1'b1;
			hold_left = HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 9) != 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// monitor: check the result beat first, then predict for the request beat
	always @(posedge clk) begin
		grant_t   want;
		request_t got;
		in_took = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					$error("result beat with none outstanding: given_id %0d status %0d",
						given_id, status);
					fails++;
				end else begin
					want = grants_due.pop_front();
					if (given_id !== want.given) begin
						$error("given_id: expected %0d, got %0d", want.given, given_id);
						fails++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				got.func = func;
				got.kind = kind;
				got.ident = ident;
				grants_due.push_back(predict_grant(got));
				beats_in++;
				in_took = 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_MAX) begin
			$display("** typed_id_allocator: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < NUM_KINDS; k++) begin
			stack_fill[k] = 0;
			fresh_next[k] = '0;
		end

		// directed: fresh ids per kind, zero and extreme ids, LIFO order
		for (int k = 0; k < 4; k++) begin
			queue_request(FN_ALLOCATE, KIND_W'(k), 16'h0000);
		end
		queue_request(FN_RELEASE, 2'd0, 16'h0000);
		queue_request(FN_RELEASE, 2'd0, 16'hFFFF);
		queue_request(FN_RELEASE, 2'd0, 16'h0001);
		queue_request(FN_ALLOCATE, 2'd0, 16'hFFFF);
		queue_request(FN_ALLOCATE, 2'd0, 16'h0000);
		queue_request(FN_ALLOCATE, 2'd0, 16'h1234);
		queue_request(FN_RELEASE, 2'd1, 16'hAAAA);
		queue_request(FN_RELEASE, 2'd2, 16'h5555);
		queue_request(FN_RELEASE, 2'd3, 16'h8000);
		queue_request(FN_RELEASE, 2'd3, 16'h0000);
		queue_request(FN_ALLOCATE, 2'd1, 16'h0000);
		queue_request(FN_ALLOCATE, 2'd2, 16'h0000);
		queue_request(FN_ALLOCATE, 2'd3, 16'h0000);
		queue_request(FN_ALLOCATE, 2'd3, 16'hFFFF);
		queue_request(FN_RELEASE, 2'd3, 16'h7FFF);
		queue_request(FN_ALLOCATE, 2'd3, 16'h0000);

		queue_mixed(900);

		// overfill one stack, then drain it into the fresh counter
		for (int i = 0; i < FREE_DEPTH + 14; i++) begin
			queue_request(FN_RELEASE, 2'd1, IDENT_W'($urandom_range(1, 16'hFFFF)));
		end
		for (int i = 0; i < FREE_DEPTH + 24; i++) begin
			queue_request(FN_ALLOCATE, 2'd1, IDENT_W'($urandom_range(0, 16'hFFFF)));
		end

		// drain another stack into its counter, then reuse
		for (int i = 0; i < 300; i++) begin
			queue_request(FN_ALLOCATE, 2'd2, '0);
		end
		queue_request(FN_RELEASE, 2'd2, 16'h0000);
		queue_request(FN_RELEASE, 2'd2, 16'hBEEF);
		queue_request(FN_RELEASE, 2'd2, 16'h0002);
		for (int i = 0; i < 5; i++) begin
			queue_request(FN_ALLOCATE, 2'd2, '0);
		end

		queue_mixed(300);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_in < requests_total || grants_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("** typed_id_allocator: PASSED **");
		end else begin
			$display("** typed_id_allocator: FAILED **");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tia_pkg.sv
rtl/tia_ram.sv
rtl/tia_front.sv
rtl/tia_back.sv
rtl/typed_id_allocator.sv
rtl/tia_checker.sv
test/testbench.sv
